### design/point_view_angle_jet_colour_unit_defines.svh
// Assertion macros shared by the view-angle colouring design.
// Depends on nothing; include by bare file name.
`ifndef POINT_VIEW_ANGLE_JET_COLOUR_UNIT_DEFINES_SVH
`define POINT_VIEW_ANGLE_JET_COLOUR_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define PVAJ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pvaj: implication check failed");

// Check that a condition is followed by another after the delay given by dly.
`define PVAJ_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("pvaj: delayed check failed");

`endif

### design/pvaj_pkg.sv
// Types, widths and tables for the view-angle colouring pipeline.
// Depends on nothing.
`default_nettype none
package pvaj_pkg;

  localparam int CoordW         = 24;
  localparam int NormW          = 16;
  localparam int NegW           = NormW + 1;
  localparam int ProdW          = CoordW + NegW;
  localparam int SumW           = ProdW + 2;
  localparam int ShW            = $clog2(SumW);
  localparam int NormBits       = 29;
  localparam int SqW            = 2 * NormBits;
  localparam int SsW            = SqW + 2;
  localparam int RootW          = SsW / 2;
  localparam int RemW           = RootW + 3;
  localparam int CordW          = RootW + 4;
  localparam int FracW          = 33;
  localparam int ChanW          = 8;
  localparam int AtanLen        = 24;
  localparam int AngleStagesDef = 16;

  localparam logic [31:0] AtanTurns [AtanLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic signed [NormW-1:0]  norm_x;
    logic signed [NormW-1:0]  norm_y;
    logic signed [NormW-1:0]  norm_z;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic [ChanW-1:0]         red;
    logic [ChanW-1:0]         green;
    logic [ChanW-1:0]         blue;
  } res_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  // Side data riding along the square-root chain.
  typedef struct packed {
    point_t              pt;
    logic                zero;
    logic                dneg;
    logic [NormBits-1:0] md;
  } sq_side_t;

  typedef struct packed {
    logic [SsW-1:0]   n;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_state_t;

  typedef struct packed {
    point_t pt;
    logic   zero;
  } cord_side_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
  } cord_state_t;

  // Colour fraction in Q1.32 times 255, truncated.
  function automatic logic [ChanW-1:0] chan_of(input logic [FracW-1:0] f);
    logic [FracW+ChanW-1:0] p;
    p = {{ChanW{1'b0}}, f} * (FracW + ChanW)'(255);
    return p[FracW+ChanW-2:FracW-1];
  endfunction

endpackage
`default_nettype wire

### design/pvaj_sqrt_cell.sv
// One digit cell of the integer square-root chain.
// Depends on pvaj_pkg.
`default_nettype none
module pvaj_sqrt_cell import pvaj_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire sq_state_t st_i,
  input  wire sq_side_t  side_i,
  output logic           valid_o,
  output sq_state_t      st_o,
  output sq_side_t       side_o
);

  logic      valid_q;
  sq_state_t st_d, st_q;
  sq_side_t  side_q;
  logic [RemW-1:0] cat, trial;

  always_comb begin
    cat   = {1'b0, st_i.rem[RemW-4:0], st_i.n[SsW-1 -: 2]};
    trial = {1'b0, st_i.root, 2'b01};
    st_d.n = {st_i.n[SsW-3:0], 2'b00};
    if (cat >= trial) begin
      st_d.rem  = cat - trial;
      st_d.root = {st_i.root[RootW-2:0], 1'b1};
    end else begin
      st_d.rem  = cat;
      st_d.root = {st_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

### design/pvaj_cordic_cell.sv
// One rotation cell of the vectoring angle chain.
// Depends on pvaj_pkg.
`default_nettype none
module pvaj_cordic_cell import pvaj_pkg::*; #(
  parameter int Idx = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire cord_state_t st_i,
  input  wire cord_side_t  side_i,
  output logic             valid_o,
  output cord_state_t      st_o,
  output cord_side_t       side_o
);

  localparam logic signed [CordW-1:0] Step = CordW'(AtanTurns[Idx]);

  logic        valid_q;
  cord_state_t st_d, st_q;
  cord_side_t  side_q;
  logic signed [CordW-1:0] xs, ys;

  always_comb begin
    xs = st_i.x >>> Idx;
    ys = st_i.y >>> Idx;
    if (!st_i.y[CordW-1]) begin
      st_d.x = st_i.x + ys;
      st_d.y = st_i.y - xs;
      st_d.z = st_i.z + Step;
    end else begin
      st_d.x = st_i.x - ys;
      st_d.y = st_i.y + xs;
      st_d.z = st_i.z - Step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

### design/point_view_angle_jet_colour_unit.sv
// Top level of the view-angle jet colouring pipeline.
// Depends on pvaj_pkg, pvaj_sqrt_cell, pvaj_cordic_cell and the defines header.
//
// Usage:
//   Request channel: drive req_i and pulse start_i; a request is taken at
//   every rising edge with start_i high and busy_o low. busy_o stays low, so
//   a new request may enter in every cycle, one point per clock.
//   Result channel: done_o is high for exactly one cycle with res_o holding
//   the point and its red, green and blue values. The receiver cannot stall;
//   results leave in request order and must be captured when done_o is high.
//   Pipeline: a request passes 39 + ANGLE_STAGES registers, the first
//   loaded at the accepting edge and the last driving done_o and res_o:
//   seven preparation stages (negate, products, sums, magnitudes, normalize,
//   squares, sum of squares), one square-root cell per result bit (30), one
//   swap stage, one CORDIC cell per angle stage and the colour stage.
//   Throughput is one point per cycle set by the cell chain.
//   Reset: clears all valid bits; requests in flight are dropped and no
//   result appears until new requests arrive. No clearing pass is needed.
`default_nettype none
`include "point_view_angle_jet_colour_unit_defines.svh"
module point_view_angle_jet_colour_unit import pvaj_pkg::*; #(
  parameter int ANGLE_STAGES = AngleStagesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output res_t      res_o
);

  localparam int PrepStages = 7;
  localparam int Lat        = PrepStages + RootW + 1 + ANGLE_STAGES + 1;
  localparam logic [FracW-1:0] One   = FracW'(64'h1_0000_0000);
  localparam logic [FracW-1:0] Qtr   = FracW'(64'h4000_0000);
  localparam logic [FracW+1:0] One4  = (FracW+2)'(64'h4_0000_0000);
  localparam logic [FracW+1:0] Two4  = (FracW+2)'(64'h2_0000_0000);

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  // Stage 0: hold request, negate normal.
  logic v0_q;
  point_t pt0_q;
  logic signed [NegW-1:0] nx0_q, ny0_q, nz0_q;

  // Stage 1: products.
  logic v1_q;
  point_t pt1_q;
  logic signed [ProdW-1:0] nypz_q, nzpy_q, nzpx_q, nxpz_q, nxpy_q, nypx_q;
  logic signed [ProdW-1:0] nxpx_q, nypy_q, nzpz_q;

  // Stage 2: cross and dot.
  logic v2_q;
  point_t pt2_q;
  logic signed [SumW-1:0] cx2_q, cy2_q, cz2_q, d2_q;

  // Stage 3: magnitudes.
  logic v3_q;
  point_t pt3_q;
  logic [SumW-1:0] mx3_q, my3_q, mz3_q, md3_q, mor3_q;
  logic dneg3_q;

  // Stage 4: normalized magnitudes.
  logic v4_q;
  point_t pt4_q;
  logic [NormBits-1:0] mx4_q, my4_q, mz4_q, md4_q;
  logic dneg4_q, zero4_q;
  logic [ShW-1:0] hi_bit, sh;
  logic [SumW-1:0] sx, sy, sz, sd;

  // Stage 5: squares.
  logic v5_q;
  sq_side_t side5_q;
  logic [SqW-1:0] qx5_q, qy5_q, qz5_q;

  // Stage 6: sum of squares.
  logic v6_q;
  sq_side_t side6_q;
  logic [SsW-1:0] ss6_q;

  always_comb begin
    hi_bit = '0;
    for (int i = 0; i < SumW; i++) begin
      if (mor3_q[i]) hi_bit = ShW'(i);
    end
    sh = (hi_bit >= ShW'(NormBits)) ? hi_bit - ShW'(NormBits - 1) : '0;
    sx = mx3_q >> sh;
    sy = my3_q >> sh;
    sz = mz3_q >> sh;
    sd = md3_q >> sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pt0_q.x <= req_i.point_x;
    pt0_q.y <= req_i.point_y;
    pt0_q.z <= req_i.point_z;
    nx0_q   <= -NegW'(req_i.norm_x);
    ny0_q   <= -NegW'(req_i.norm_y);
    nz0_q   <= -NegW'(req_i.norm_z);

    pt1_q  <= pt0_q;
    nypz_q <= ProdW'(ny0_q * pt0_q.z);
    nzpy_q <= ProdW'(nz0_q * pt0_q.y);
    nzpx_q <= ProdW'(nz0_q * pt0_q.x);
    nxpz_q <= ProdW'(nx0_q * pt0_q.z);
    nxpy_q <= ProdW'(nx0_q * pt0_q.y);
    nypx_q <= ProdW'(ny0_q * pt0_q.x);
    nxpx_q <= ProdW'(nx0_q * pt0_q.x);
    nypy_q <= ProdW'(ny0_q * pt0_q.y);
    nzpz_q <= ProdW'(nz0_q * pt0_q.z);

    pt2_q <= pt1_q;
    cx2_q <= SumW'(nypz_q) - SumW'(nzpy_q);
    cy2_q <= SumW'(nzpx_q) - SumW'(nxpz_q);
    cz2_q <= SumW'(nxpy_q) - SumW'(nypx_q);
    d2_q  <= SumW'(nxpx_q) + SumW'(nypy_q) + SumW'(nzpz_q);

    pt3_q   <= pt2_q;
    mx3_q   <= cx2_q[SumW-1] ? -cx2_q : cx2_q;
    my3_q   <= cy2_q[SumW-1] ? -cy2_q : cy2_q;
    mz3_q   <= cz2_q[SumW-1] ? -cz2_q : cz2_q;
    md3_q   <= d2_q[SumW-1] ? -d2_q : d2_q;
    mor3_q  <= (cx2_q[SumW-1] ? -cx2_q : cx2_q) | (cy2_q[SumW-1] ? -cy2_q : cy2_q)
             | (cz2_q[SumW-1] ? -cz2_q : cz2_q) | (d2_q[SumW-1] ? -d2_q : d2_q);
    dneg3_q <= d2_q[SumW-1];

    pt4_q   <= pt3_q;
    mx4_q   <= sx[NormBits-1:0];
    my4_q   <= sy[NormBits-1:0];
    mz4_q   <= sz[NormBits-1:0];
    md4_q   <= sd[NormBits-1:0];
    dneg4_q <= dneg3_q;
    zero4_q <= (mor3_q == '0);

    side5_q.pt   <= pt4_q;
    side5_q.zero <= zero4_q;
    side5_q.dneg <= dneg4_q;
    side5_q.md   <= md4_q;
    qx5_q <= SqW'(mx4_q) * SqW'(mx4_q);
    qy5_q <= SqW'(my4_q) * SqW'(my4_q);
    qz5_q <= SqW'(mz4_q) * SqW'(mz4_q);

    side6_q <= side5_q;
    ss6_q   <= SsW'(qx5_q) + SsW'(qy5_q) + SsW'(qz5_q);
  end

  // Square-root chain: one result bit per cell, most significant first.
  logic      sv   [RootW+1];
  sq_state_t sst  [RootW+1];
  sq_side_t  sside[RootW+1];

  assign sv[0]        = v6_q;
  assign sst[0].n     = ss6_q;
  assign sst[0].rem   = '0;
  assign sst[0].root  = '0;
  assign sside[0]     = side6_q;

  for (genvar g = 0; g < RootW; g++) begin : g_sqrt
    pvaj_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[g]),
      .st_i    (sst[g]),
      .side_i  (sside[g]),
      .valid_o (sv[g+1]),
      .st_o    (sst[g+1]),
      .side_o  (sside[g+1])
    );
  end

  // Swap stage: fold a negative dot product into the second quadrant.
  logic        v7_q;
  cord_state_t cst7_q;
  cord_side_t  cside7_q;
  logic        left;

  assign left = sside[RootW].dneg && (sside[RootW].md != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= sv[RootW];
    end
  end

  always_ff @(posedge clk_i) begin
    cside7_q.pt   <= sside[RootW].pt;
    cside7_q.zero <= sside[RootW].zero;
    if (left) begin
      cst7_q.x <= CordW'(sst[RootW].root);
      cst7_q.y <= CordW'(sside[RootW].md);
      cst7_q.z <= CordW'(Qtr);
    end else begin
      cst7_q.x <= CordW'(sside[RootW].md);
      cst7_q.y <= CordW'(sst[RootW].root);
      cst7_q.z <= '0;
    end
  end

  // CORDIC chain: one rotation per cell.
  logic        cv   [ANGLE_STAGES+1];
  cord_state_t cst  [ANGLE_STAGES+1];
  cord_side_t  cside[ANGLE_STAGES+1];

  assign cv[0]    = v7_q;
  assign cst[0]   = cst7_q;
  assign cside[0] = cside7_q;

  for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_cordic
    pvaj_cordic_cell #(.Idx(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[g]),
      .st_i    (cst[g]),
      .side_i  (cside[g]),
      .valid_o (cv[g+1]),
      .st_o    (cst[g+1]),
      .side_o  (cside[g+1])
    );
  end

  // Colour stage: clamp the angle and map through jet.
  logic signed [CordW-1:0] zf;
  logic [FracW-1:0] ang;
  logic [FracW+1:0] ang4;
  logic [FracW-1:0] fr, fg, fb;
  logic done_q;
  res_t res_q;

  always_comb begin
    zf = cst[ANGLE_STAGES].z;
    if (cside[ANGLE_STAGES].zero || zf[CordW-1]) begin
      ang = '0;
    end else if (zf > $signed({1'b0, One})) begin
      ang = One;
    end else begin
      ang = zf[FracW-1:0];
    end
    ang4 = {ang, 2'b00};
    priority if (ang < Qtr) begin
      fr = '0;
      fg = ang4[FracW-1:0];
      fb = One;
    end else if (ang < (Qtr << 1)) begin
      fr = '0;
      fg = One;
      fb = FracW'(Two4 - ang4);
    end else if (ang < (Qtr + (Qtr << 1))) begin
      fr = FracW'(ang4 - Two4);
      fg = One;
      fb = '0;
    end else begin
      fr = One;
      fg = FracW'(One4 - ang4);
      fb = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cv[ANGLE_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.out_x <= cside[ANGLE_STAGES].pt.x;
    res_q.out_y <= cside[ANGLE_STAGES].pt.y;
    res_q.out_z <= cside[ANGLE_STAGES].pt.z;
    res_q.red   <= chan_of(fr);
    res_q.green <= chan_of(fg);
    res_q.blue  <= chan_of(fb);
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Jet always drives at least one channel to full scale.
  logic sat_chan;
  assign sat_chan = (&res_o.red) || (&res_o.green) || (&res_o.blue);

  `PVAJ_ASSERT_DELAY(a_latency, clk_i, rst_ni, accept, Lat, done_o)
  `PVAJ_ASSERT_IMPLY(a_full_chan, clk_i, rst_ni, done_o, sat_chan)
  `PVAJ_ASSERT_IMPLY(a_red_blue, clk_i, rst_ni, done_o, (res_o.red == '0) || (res_o.blue == '0))
  `PVAJ_ASSERT_IMPLY(a_zero_blue, clk_i, rst_ni, cv[ANGLE_STAGES] && cside[ANGLE_STAGES].zero, (fb == One) && (fg == '0))

endmodule
`default_nettype wire
